// ===== design/asg_pkg.sv =====
// types and constants shared by the greedy activity selection block
// no dependencies

package asg_pkg;

   localparam int TAG_W   = 8;
   localparam int TIME_W  = 16;
   localparam int TOTAL_W = 5;

   typedef struct packed {
      logic              valid;
      logic              pick;
      logic [TAG_W-1:0]  tag;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] finish;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ROTATE = 2'd2,
      CELL_CLEAR  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   new_item;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_LOAD = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ===== design/asg_channels.sv =====
// valid/ready channel interfaces for activity items and chosen results
// depends on asg_pkg

interface asg_req_if;
   import asg_pkg::*;
   logic              valid;
   logic              ready;
   logic [TAG_W-1:0]  activity_tag;
   logic [TIME_W-1:0] start_time;
   logic [TIME_W-1:0] finish_time;
   logic              last_item;

   modport source (output valid, activity_tag, start_time, finish_time, last_item,
                   input ready);
   modport sink   (input valid, activity_tag, start_time, finish_time, last_item,
                   output ready);
endinterface

interface asg_rsp_if;
   import asg_pkg::*;
   logic               valid;
   logic               ready;
   logic [TAG_W-1:0]   chosen_tag;
   logic [TOTAL_W-1:0] chosen_total;
   logic               final_choice;
   logic               overflowed;

   modport source (output valid, chosen_tag, chosen_total, final_choice, overflowed,
                   input ready);
   modport sink   (input valid, chosen_tag, chosen_total, final_choice, overflowed,
                   output ready);
endinterface

// ===== design/activity_selection_greedy_top.sv =====
// top level of greedy activity selection: insertion chain, scan and output stage
// depends on asg_pkg, asg_channels, asg_cell
//
//   channel  dir  handshake          payload
//   req      in   req.valid/ready    activity_tag, start_time, finish_time, last_item
//   rsp      out  rsp.valid/ready    chosen_tag, chosen_total, final_choice, overflowed
//
// loading accepts one item per cycle; each item is sorted into the cell chain as it arrives
// after an item marked last, a scan pass rotates the chain through every cell and
// marks the greedy picks, then an emit pass, which stalls on a pick while rsp is held,
// sends them out; req.ready is low for both passes
// reset is synchronous and empties the chain; the rsp register holds while rsp.ready is low

module activity_selection_greedy_top #(
   parameter int MAX_ACTIVITIES = 16
) (
   input  logic      clock,
   input  logic      reset,
   asg_req_if.sink   req,
   asg_rsp_if.source rsp
);
   import asg_pkg::*;

   localparam int CW = $clog2(MAX_ACTIVITIES + 1);
   localparam logic [CW-1:0] LAST_POS = CW'(MAX_ACTIVITIES - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(MAX_ACTIVITIES);

   state_type          state_ff, state_in;
   logic [CW-1:0]      entry_cnt_ff, entry_cnt_in;
   logic               overflow_ff, overflow_in;
   logic [CW-1:0]      pos_ff, pos_in;
   logic [CW-1:0]      pick_cnt_ff, pick_cnt_in;
   logic [CW-1:0]      remain_ff, remain_in;
   logic               first_ff, first_in;
   logic [TIME_W-1:0]  last_fin_ff, last_fin_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [TAG_W-1:0]   rsp_tag_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_final_ff;
   logic               rsp_ovf_ff;

   cell_ctl_type          ctl;
   entry_type             chain [MAX_ACTIVITIES];
   logic [MAX_ACTIVITIES-1:0] greater_vec;
   logic [MAX_ACTIVITIES-1:0] valid_vec;
   entry_type             head;
   entry_type             tail_in;
   logic                  pick_now;
   logic                  out_free;
   logic                  emit_load;
   logic                  req_take;

   assign head     = chain[0];
   assign pick_now = head.valid && (first_ff || (head.start >= last_fin_ff));
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign req_take = req.valid && req.ready;

   always_comb begin
      tail_in = head;
      if (state_ff == ST_SCAN) begin
         tail_in.pick = pick_now;
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < MAX_ACTIVITIES; gi++) begin : g_cell
         entry_type pe, ne;
         logic      pg;
         if (gi == 0) begin : g_first
            assign pe = ctl.new_item;
            assign pg = 1'b0;
         end else begin : g_mid
            assign pe = chain[gi-1];
            assign pg = greater_vec[gi-1];
         end
         if (gi == MAX_ACTIVITIES - 1) begin : g_tail
            assign ne = tail_in;
         end else begin : g_body
            assign ne = chain[gi+1];
         end
         assign valid_vec[gi] = chain[gi].valid;
         asg_cell u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctl          (ctl),
            .prev_entry   (pe),
            .prev_greater (pg),
            .next_entry   (ne),
            .entry        (chain[gi]),
            .greater      (greater_vec[gi])
         );
      end
   endgenerate

   assign req.ready = (state_ff == ST_LOAD);

   always_comb begin
      state_in     = state_ff;
      entry_cnt_in = entry_cnt_ff;
      overflow_in  = overflow_ff;
      pos_in       = pos_ff;
      pick_cnt_in  = pick_cnt_ff;
      remain_in    = remain_ff;
      first_in     = first_ff;
      last_fin_in  = last_fin_ff;
      emit_load    = 1'b0;
      ctl.op       = CELL_HOLD;
      ctl.new_item.valid  = 1'b1;
      ctl.new_item.pick   = 1'b0;
      ctl.new_item.tag    = req.activity_tag;
      ctl.new_item.start  = req.start_time;
      ctl.new_item.finish = req.finish_time;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (entry_cnt_ff != FULL_CNT) begin
                  ctl.op       = CELL_INSERT;
                  entry_cnt_in = entry_cnt_ff + 1'b1;
               end else begin
                  overflow_in = 1'b1;
               end
               if (req.last_item) begin
                  state_in    = ST_SCAN;
                  pos_in      = '0;
                  pick_cnt_in = '0;
                  first_in    = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            ctl.op = CELL_ROTATE;
            if (pick_now) begin
               pick_cnt_in = pick_cnt_ff + 1'b1;
               last_fin_in = head.finish;
               first_in    = 1'b0;
            end
            pos_in = pos_ff + 1'b1;
            if (pos_ff == LAST_POS) begin
               state_in  = ST_EMIT;
               pos_in    = '0;
               remain_in = pick_now ? pick_cnt_ff + 1'b1 : pick_cnt_ff;
            end
         end
         ST_EMIT: begin
            if (!(head.valid && head.pick) || out_free) begin
               ctl.op = (pos_ff == LAST_POS) ? CELL_CLEAR : CELL_ROTATE;
               pos_in = pos_ff + 1'b1;
               if (head.valid && head.pick) begin
                  emit_load = 1'b1;
                  remain_in = remain_ff - 1'b1;
               end
               if (pos_ff == LAST_POS) begin
                  state_in     = ST_LOAD;
                  pos_in       = '0;
                  entry_cnt_in = '0;
                  overflow_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         entry_cnt_ff <= '0;
         overflow_ff  <= 1'b0;
         pos_ff       <= '0;
         pick_cnt_ff  <= '0;
         remain_ff    <= '0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         entry_cnt_ff <= entry_cnt_in;
         overflow_ff  <= overflow_in;
         pos_ff       <= pos_in;
         pick_cnt_ff  <= pick_cnt_in;
         remain_ff    <= remain_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_fin_ff <= last_fin_in;
      if (emit_load) begin
         rsp_tag_ff   <= head.tag;
         rsp_total_ff <= TOTAL_W'(pick_cnt_ff);
         rsp_final_ff <= (remain_ff == CW'(1));
         rsp_ovf_ff   <= overflow_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.chosen_tag   = rsp_tag_ff;
   assign rsp.chosen_total = rsp_total_ff;
   assign rsp.final_choice = rsp_final_ff;
   assign rsp.overflowed   = rsp_ovf_ff;

   // chain stays packed from the head while loading
   a_chain_packed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($countones(valid_vec) == int'(entry_cnt_ff)))
      else $error("cell chain occupancy differs from entry count");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (entry_cnt_ff == FULL_CNT))
      else $error("overflow raised with room left");

   a_emit_has_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (pick_cnt_ff != '0))
      else $error("emit pass with no chosen activity");

   a_remain_start: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && ($past(state_ff) == ST_SCAN)) |-> (remain_ff == pick_cnt_ff))
      else $error("remaining count not loaded from pick count");

   a_final_last: assert property (@(posedge clock) disable iff (reset)
      (emit_load && (remain_ff == CW'(1))) |=> (state_ff == ST_LOAD || !head.pick
                                                || !head.valid || pos_ff != '0))
      else $error("final choice emitted before chain end");

endmodule

// ===== design/asg_cell.sv =====
// one cell of the insertion chain: holds one activity, sorted by finish time
// depends on asg_pkg

module asg_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  asg_pkg::cell_ctl_type ctl,
   input  asg_pkg::entry_type    prev_entry,
   input  logic                  prev_greater,
   input  asg_pkg::entry_type    next_entry,
   output asg_pkg::entry_type    entry,
   output logic                  greater
);
   import asg_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // empty cells act as an infinite finish
   assign greater = !entry_ff.valid || (entry_ff.finish > ctl.new_item.finish);
   assign entry   = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (prev_greater) begin
               entry_in = prev_entry;
            end else if (greater) begin
               entry_in = ctl.new_item;
            end
         end
         CELL_ROTATE: begin
            entry_in = next_entry;
         end
         CELL_CLEAR: begin
            entry_in.valid = 1'b0;
            entry_in.pick  = 1'b0;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule
